/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
// Self-contained; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted (active low).
`define DRSVC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("drsvc: assertion failed");

// Same assertion with a caller-supplied message.
`define DRSVC_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

/* rtl/core/drsvc_pkg.sv */
// Types, constants and helper functions for the disc robot validity checker.
// No dependencies.
package drsvc_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned SizeW    = 15;
  localparam int unsigned SlotW    = 6;
  localparam int unsigned CountW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  // doubled position, edge and offset widths
  localparam int unsigned Pos2W    = CoordW + 1;
  localparam int unsigned EdgeW    = CoordW + 2;
  localparam int unsigned DiffW    = CoordW + 3;
  localparam int unsigned R2SqW    = 32;
  localparam int unsigned SumW     = 2 * DiffW + 1;

  // 3.14 rad in Q3.12, rounded towards zero
  localparam logic signed [15:0] HeadingBound = 16'sd12861;

  localparam logic [CfgIdxW-1:0] RegRadius = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLimitX = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLimitY = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCount  = 3'd3;

  localparam logic KindQuery = 1'b0;
  localparam logic KindLoad  = 1'b1;

  localparam logic [1:0] CauseOk      = 2'd0;
  localparam logic [1:0] CauseBounds  = 2'd1;
  localparam logic [1:0] CauseHit     = 2'd2;
  localparam logic [1:0] CauseHeading = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [15:0]       heading;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] box_x;
    logic signed [CoordW-1:0] box_y;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_height;
  } in_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [1:0] cause;
  } out_item_t;

  // Control part of the link between neighbouring cells.
  typedef struct packed {
    logic vld;      // query token present
    logic hit;      // a hit already found upstream
    logic prev_en;  // previous cell's obstacle is in use
    logic prev_in;  // centre strictly inside previous cell's box
  } link_ctl_t;

  // Second half of the disc/box test, done one cell downstream.
  function automatic logic dist_hit(input logic signed [DiffW-1:0] dx,
                                    input logic signed [DiffW-1:0] dy,
                                    input logic [R2SqW-1:0]        r2sq);
    logic signed [2*DiffW-1:0] sx;
    logic signed [2*DiffW-1:0] sy;
    logic [SumW-1:0]           s;
    sx = (2*DiffW)'(dx) * (2*DiffW)'(dx);
    sy = (2*DiffW)'(dy) * (2*DiffW)'(dy);
    s  = {1'b0, sx} + {1'b0, sy};
    return s <= {{(SumW-R2SqW){1'b0}}, r2sq};
  endfunction

endpackage

/* rtl/core/disc_robot_state_validity_check.sv */
// Disc robot pose validity checker: a chain of MAX_OBSTACLES box cells.
// Load transaction: does not stall the input, so a new item can be taken the next cycle.
// Query transaction: the token passes the launch register, each cell register, the
// pending register and the output register; no new item is taken until the result
// reaches the output register, later while the output stall holds an earlier result.
// Reset (async, active low) restores config and control registers, not box or data registers.
module disc_robot_state_validity_check #(
  parameter int unsigned MAX_OBSTACLES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [drsvc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [drsvc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  drsvc_pkg::in_item_t              in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output drsvc_pkg::out_item_t             out_item_o
);
  import drsvc_pkg::*;

  logic [SizeW-1:0]         radius_q, limx_q, limy_q;
  logic [CountW-1:0]        count_q;
  logic                     busy_q, launch_q;
  logic signed [Pos2W-1:0]  px2_q, py2_q;
  logic [R2SqW-1:0]         r2sq_q;
  logic                     bounds_q, head_q;
  logic                     pend_q, out_vld_q;
  logic [1:0]               pend_cause_q;
  out_item_t                out_q;
  logic                     acc, load, query, fin_hit, move;
  logic signed [EdgeW-1:0]  pxe, pye, re, lo_x, hi_x, lo_y, hi_y;
  logic [15:0]              r2;
  link_ctl_t                ctl [MAX_OBSTACLES+1];
  logic signed [DiffW-1:0]  dx [MAX_OBSTACLES+1];
  logic signed [DiffW-1:0]  dy [MAX_OBSTACLES+1];

  assign in_stall_o = busy_q;
  assign acc   = in_valid_i & ~busy_q;
  assign load  = acc & (in_item_i.kind == KindLoad);
  assign query = acc & (in_item_i.kind == KindQuery);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= SizeW'(16);
      limx_q   <= SizeW'(32767);
      limy_q   <= SizeW'(32767);
      count_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRadius: radius_q <= cfg_data_i;
        RegLimitX: limx_q   <= cfg_data_i;
        RegLimitY: limy_q   <= cfg_data_i;
        RegCount:  count_q  <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // workspace and heading checks at acceptance
  always_comb begin
    pxe  = EdgeW'(in_item_i.pos_x);
    pye  = EdgeW'(in_item_i.pos_y);
    re   = EdgeW'(radius_q);
    lo_x = pxe - re;
    hi_x = pxe + re;
    lo_y = pye - re;
    hi_y = pye + re;
    r2   = {radius_q, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (query) begin
      px2_q    <= {in_item_i.pos_x, 1'b0};
      py2_q    <= {in_item_i.pos_y, 1'b0};
      r2sq_q   <= R2SqW'(r2) * R2SqW'(r2);
      bounds_q <= lo_x[EdgeW-1] | (hi_x > EdgeW'(limx_q)) |
                  lo_y[EdgeW-1] | (hi_y > EdgeW'(limy_q));
      head_q   <= (in_item_i.heading > HeadingBound) ||
                  (in_item_i.heading < -HeadingBound);
    end
  end

  assign ctl[0] = '{vld: launch_q, hit: 1'b0, prev_en: 1'b0, prev_in: 1'b0};
  assign dx[0]  = '0;
  assign dy[0]  = '0;

  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    drsvc_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load),
      .slot_i  (in_item_i.slot),
      .cx_i    (in_item_i.box_x),
      .cy_i    (in_item_i.box_y),
      .w_i     (in_item_i.box_width),
      .h_i     (in_item_i.box_height),
      .count_i (count_q),
      .px2_i   (px2_q),
      .py2_i   (py2_q),
      .r2sq_i  (r2sq_q),
      .ctl_i   (ctl[i]),
      .dx_i    (dx[i]),
      .dy_i    (dy[i]),
      .ctl_o   (ctl[i+1]),
      .dx_o    (dx[i+1]),
      .dy_o    (dy[i+1])
    );
  end

  // last cell's distance test finishes here
  assign fin_hit = ctl[MAX_OBSTACLES].hit | (ctl[MAX_OBSTACLES].prev_en &
                   (ctl[MAX_OBSTACLES].prev_in |
                    dist_hit(dx[MAX_OBSTACLES], dy[MAX_OBSTACLES], r2sq_q)));
  assign move = pend_q & (~out_vld_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      launch_q  <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      launch_q <= query;
      if (query) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (ctl[MAX_OBSTACLES].vld) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl[MAX_OBSTACLES].vld) begin
      pend_cause_q <= bounds_q ? CauseBounds :
                      fin_hit  ? CauseHit    :
                      head_q   ? CauseHeading : CauseOk;
    end
    if (move) begin
      out_q.cause     <= pend_cause_q;
      out_q.valid_res <= (pend_cause_q == CauseOk);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/core/drsvc_cell.sv */
// One obstacle cell of the checker chain: holds a box and tests the token.
// Depends on drsvc_pkg.
module drsvc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [drsvc_pkg::SlotW-1:0]         slot_i,
  input  logic signed [drsvc_pkg::CoordW-1:0] cx_i,
  input  logic signed [drsvc_pkg::CoordW-1:0] cy_i,
  input  logic [drsvc_pkg::SizeW-1:0]         w_i,
  input  logic [drsvc_pkg::SizeW-1:0]         h_i,
  input  logic [drsvc_pkg::CountW-1:0]        count_i,
  input  logic signed [drsvc_pkg::Pos2W-1:0]  px2_i,
  input  logic signed [drsvc_pkg::Pos2W-1:0]  py2_i,
  input  logic [drsvc_pkg::R2SqW-1:0]         r2sq_i,
  input  drsvc_pkg::link_ctl_t                ctl_i,
  input  logic signed [drsvc_pkg::DiffW-1:0]  dx_i,
  input  logic signed [drsvc_pkg::DiffW-1:0]  dy_i,
  output drsvc_pkg::link_ctl_t                ctl_o,
  output logic signed [drsvc_pkg::DiffW-1:0]  dx_o,
  output logic signed [drsvc_pkg::DiffW-1:0]  dy_o
);
  import drsvc_pkg::*;

  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [SizeW-1:0]         w_q, h_q;
  logic signed [EdgeW-1:0]  left, right, top, bottom, pxe, pye, clx, cly;
  logic                     in_box, en;
  link_ctl_t                ctl_d, ctl_q;
  logic signed [DiffW-1:0]  dx_d, dy_d, dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (load_i && (32'(slot_i) == IDX)) begin
      cx_q <= cx_i;
      cy_q <= cy_i;
      w_q  <= w_i;
      h_q  <= h_i;
    end
  end

  always_comb begin
    left   = {cx_q[CoordW-1], cx_q, 1'b0} - EdgeW'(w_q);
    right  = {cx_q[CoordW-1], cx_q, 1'b0} + EdgeW'(w_q);
    top    = {cy_q[CoordW-1], cy_q, 1'b0} - EdgeW'(h_q);
    bottom = {cy_q[CoordW-1], cy_q, 1'b0} + EdgeW'(h_q);
    pxe    = {px2_i[Pos2W-1], px2_i};
    pye    = {py2_i[Pos2W-1], py2_i};
    in_box = (pxe > left) && (pxe < right) && (pye > top) && (pye < bottom);
    clx    = (pxe < left) ? left : ((pxe > right) ? right : pxe);
    cly    = (pye < top) ? top : ((pye > bottom) ? bottom : pye);
    dx_d   = {pxe[EdgeW-1], pxe} - {clx[EdgeW-1], clx};
    dy_d   = {pye[EdgeW-1], pye} - {cly[EdgeW-1], cly};
    en     = 32'(count_i) > IDX;
    ctl_d.vld     = ctl_i.vld;
    ctl_d.hit     = ctl_i.hit | (ctl_i.vld & ctl_i.prev_en &
                    (ctl_i.prev_in | dist_hit(dx_i, dy_i, r2sq_i)));
    ctl_d.prev_en = en;
    ctl_d.prev_in = in_box;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  assign ctl_o = ctl_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;

endmodule

/* rtl/core/drsvc_checker.sv */
// Port-level checks for the validity checker, bound to the top level.
// Depends on drsvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drsvc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input drsvc_pkg::in_item_t   in_item_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input drsvc_pkg::out_item_t  out_item_o
);
  import drsvc_pkg::*;

  `DRSVC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `DRSVC_ASSERT(a_res_match, clk_i, rst_ni, out_valid_o |-> (out_item_o.valid_res == (out_item_o.cause == CauseOk)))
  `DRSVC_ASSERT(a_query_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_item_i.kind == KindQuery |=> in_stall_o)
  `DRSVC_ASSERT_MSG(a_load_free, clk_i, rst_ni, in_valid_i && !in_stall_o && in_item_i.kind == KindLoad |=> !in_stall_o, "drsvc: load left the input stalled")

endmodule

bind disc_robot_state_validity_check drsvc_checker u_drsvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
